>>> hw/rtl/pfrm_pkg.sv
package pfrm_pkg;

  localparam int POOL_FRAMES = 16;
  localparam int PAGE_BITS   = 20;

  localparam int IDX_W   = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
  localparam int NUM_W   = $clog2(POOL_FRAMES + 1);
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int FRAME_W = 4;
  localparam int COUNT_W = 32;
  localparam int PIN_W   = 8;
  localparam int STAMP_W = 32;
  localparam int POL_W   = 2;
  localparam int FR_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int MOD_CNT_W  = $clog2(COUNT_W);
  localparam int STEP_W     = IDX_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;
  localparam logic [FR_W-1:0]      FRAMES_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FN_PIN   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UNPIN = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DIRTY = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FORCE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FLUSH = 3'd4;

  localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU   = 2'd1;
  localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FRAME  = 2'd2;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
  localparam logic [OP_W-1:0] OP_LK_READ    = 4'd2;
  localparam logic [OP_W-1:0] OP_LK_CMP     = 4'd3;
  localparam logic [OP_W-1:0] OP_HIT_EMIT   = 4'd4;
  localparam logic [OP_W-1:0] OP_NF_EMIT    = 4'd5;
  localparam logic [OP_W-1:0] OP_MOD_INIT   = 4'd6;
  localparam logic [OP_W-1:0] OP_MOD_STEP   = 4'd7;
  localparam logic [OP_W-1:0] OP_FIFO_STEP  = 4'd8;
  localparam logic [OP_W-1:0] OP_CLK_STEP   = 4'd9;
  localparam logic [OP_W-1:0] OP_V_READ     = 4'd10;
  localparam logic [OP_W-1:0] OP_V_CAP      = 4'd11;
  localparam logic [OP_W-1:0] OP_COMMIT     = 4'd12;
  localparam logic [OP_W-1:0] OP_NOFREE     = 4'd13;
  localparam logic [OP_W-1:0] OP_FL_READ    = 4'd14;
  localparam logic [OP_W-1:0] OP_FL_STEP    = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            flush_none;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POL_W-1:0]  policy;
    logic              lk_hit;
    logic              idx_last;
    logic              empty_any;
    logic              lru_any;
    logic              mod_done;
    logic              fifo_hit;
    logic              fifo_end;
    logic              clk_hit;
    logic              clk_end;
    logic              fl_cond;
    logic              fl_rest;
    logic              out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic                 read_valid;
    logic [PAGE_BITS-1:0] read_page;
    logic                 write_valid;
    logic [PAGE_BITS-1:0] write_page;
    logic                 last;
    logic [COUNT_W-1:0]   read_count;
    logic [COUNT_W-1:0]   write_count;
  } rsp_t;

endpackage

>>> hw/rtl/pfrm_if.sv
interface pfrm_req_if import pfrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [PAGE_BITS-1:0] page_num;
  modport source(output valid, func, page_num, input ready);
  modport sink(input valid, func, page_num, output ready);
endinterface

interface pfrm_rsp_if import pfrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic                 hit;
  logic [FRAME_W-1:0]   frame;
  logic                 read_valid;
  logic [PAGE_BITS-1:0] read_page;
  logic                 write_valid;
  logic [PAGE_BITS-1:0] write_page;
  logic                 last;
  logic [COUNT_W-1:0]   read_count;
  logic [COUNT_W-1:0]   write_count;
  modport source(output valid, status, hit, frame, read_valid, read_page, write_valid,
                 write_page, last, read_count, write_count, input ready);
  modport sink(input valid, status, hit, frame, read_valid, read_page, write_valid,
               write_page, last, read_count, write_count, output ready);
endinterface

>>> hw/rtl/pfrm_ram.sv
module pfrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/pfrm_datapath.sv
module pfrm_datapath import pfrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [PAGE_BITS-1:0]  in_page,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output rsp_t                  out_data
);

  logic [POL_W-1:0]        policy_r;
  logic [FR_W-1:0]         frames_r;
  logic [FUNC_W-1:0]       req_func_r;
  logic [PAGE_BITS-1:0]    req_page_r;
  logic [POOL_FRAMES-1:0]  valid_r;
  logic [POOL_FRAMES-1:0]  dirty_r;
  logic [PIN_W-1:0]        pins_r  [POOL_FRAMES];
  logic [STAMP_W-1:0]      stamp_r [POOL_FRAMES];
  logic [COUNT_W-1:0]      load_r;
  logic [COUNT_W-1:0]      write_r;
  logic [COUNT_W-1:0]      use_r;
  logic [IDX_W-1:0]        hand_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        sel_r;
  logic [PAGE_BITS-1:0]    pdata_r;
  logic                    empty_any_r;
  logic [IDX_W-1:0]        empty_idx_r;
  logic                    lru_any_r;
  logic [IDX_W-1:0]        lru_idx_r;
  logic [STAMP_W-1:0]      lru_stamp_r;
  logic [IDX_W-1:0]        vict_r;
  logic [IDX_W-1:0]        ptr_r;
  logic [STEP_W-1:0]       steps_r;
  logic [COUNT_W-1:0]      div_r;
  logic [NUM_W-1:0]        rem_r;
  logic [MOD_CNT_W-1:0]    mcnt_r;
  logic                    out_valid_r;
  rsp_t                    out_r;

  logic [NUM_W-1:0]        n_act;
  logic [IDX_W-1:0]        nm1;
  logic [STEP_W-1:0]       clk_last;
  logic [IDX_W-1:0]        vsel;
  logic                    ram_re;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_raddr;
  logic [PAGE_BITS-1:0]    ram_rdata;
  logic                    match;
  logic [PIN_W-1:0]        pins_idx;
  logic [PIN_W-1:0]        pins_ptr;
  logic [STAMP_W-1:0]      stamp_ptr;
  logic [IDX_W-1:0]        ptr_wrap;
  logic [POOL_FRAMES-1:0]  cond_v;
  logic [POOL_FRAMES-1:0]  above_v;
  logic [NUM_W:0]          mod_t;
  logic [NUM_W:0]          mod_r;
  logic                    out_free;
  logic                    victim_dirty;

  always_comb begin
    if (frames_r == '0) begin
      n_act = NUM_W'(1);
    end else if (32'(frames_r) > 32'(POOL_FRAMES)) begin
      n_act = NUM_W'(POOL_FRAMES);
    end else begin
      n_act = NUM_W'(frames_r);
    end
  end

  assign nm1      = IDX_W'(n_act - 1'b1);
  assign clk_last = STEP_W'({n_act, 1'b0} - 1'b1);

  always_comb begin
    if (empty_any_r) begin
      vsel = empty_idx_r;
    end else if (policy_r == POL_LRU) begin
      vsel = lru_idx_r;
    end else begin
      vsel = vict_r;
    end
  end

  assign ram_re    = (cmd.op == OP_LK_READ) || (cmd.op == OP_FL_READ) || (cmd.op == OP_V_READ);
  assign ram_raddr = (cmd.op == OP_V_READ) ? vsel : idx_r;
  assign ram_we    = (cmd.op == OP_COMMIT);

  pfrm_ram #(.WIDTH(PAGE_BITS), .DEPTH(POOL_FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vsel),
    .wdata (req_page_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign match        = valid_r[idx_r] && (ram_rdata == req_page_r);
  assign pins_idx     = pins_r[idx_r];
  assign pins_ptr     = pins_r[ptr_r];
  assign stamp_ptr    = stamp_r[ptr_r];
  assign ptr_wrap     = (ptr_r == nm1) ? '0 : ptr_r + 1'b1;
  assign victim_dirty = !empty_any_r && dirty_r[vsel];
  assign out_free     = !out_valid_r || out_ready;

  always_comb begin
    for (int j = 0; j < POOL_FRAMES; j++) begin
      cond_v[j]  = (32'(j) < 32'(n_act)) && valid_r[j] && (pins_r[j] == '0) && dirty_r[j];
      above_v[j] = IDX_W'(j) > idx_r;
    end
  end

  // restoring remainder, one dividend bit a step
  assign mod_t = {rem_r, div_r[COUNT_W-1]};
  assign mod_r = (mod_t >= {1'b0, n_act}) ? mod_t - {1'b0, n_act} : mod_t;

  always_comb begin
    stat.func      = req_func_r;
    stat.policy    = policy_r;
    stat.lk_hit    = match;
    stat.idx_last  = (idx_r == nm1);
    stat.empty_any = empty_any_r || !valid_r[idx_r];
    stat.lru_any   = lru_any_r || (pins_idx == '0);
    stat.mod_done  = (mcnt_r == MOD_CNT_W'(COUNT_W - 1));
    stat.fifo_hit  = (pins_ptr == '0);
    stat.fifo_end  = (steps_r == STEP_W'(nm1));
    stat.clk_hit   = (pins_ptr == '0) && (stamp_ptr == '0);
    stat.clk_end   = (steps_r == clk_last);
    stat.fl_cond   = cond_v[idx_r];
    stat.fl_rest   = |(cond_v & above_v);
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIFO;
      frames_r    <= FRAMES_RESET;
      valid_r     <= '0;
      dirty_r     <= '0;
      for (int j = 0; j < POOL_FRAMES; j++) begin
        pins_r[j]  <= '0;
        stamp_r[j] <= '0;
      end
      load_r      <= '0;
      write_r     <= '0;
      use_r       <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY: policy_r <= cfg_data[POL_W-1:0];
          REG_FRAMES: frames_r <= cfg_data[FR_W-1:0];
          default: ;
        endcase
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_ACCEPT: begin
          req_func_r  <= in_func;
          req_page_r  <= in_page;
          idx_r       <= '0;
          empty_any_r <= 1'b0;
          lru_any_r   <= 1'b0;
        end
        OP_LK_CMP: begin
          if (match) begin
            sel_r   <= idx_r;
            pdata_r <= ram_rdata;
          end
          if (!valid_r[idx_r] && !empty_any_r) begin
            empty_any_r <= 1'b1;
            empty_idx_r <= idx_r;
          end
          // strict compare keeps the lowest index on a tie
          if ((pins_idx == '0) && (!lru_any_r || (stamp_r[idx_r] < lru_stamp_r))) begin
            lru_any_r   <= 1'b1;
            lru_idx_r   <= idx_r;
            lru_stamp_r <= stamp_r[idx_r];
          end
          idx_r <= idx_r + 1'b1;
        end
        OP_HIT_EMIT: begin
          out_r             <= '0;
          out_r.frame       <= FRAME_W'(sel_r);
          out_r.last        <= 1'b1;
          out_r.read_count  <= load_r;
          out_r.write_count <= write_r;
          out_valid_r       <= 1'b1;
          case (req_func_r)
            FN_PIN: begin
              if (pins_r[sel_r] != '1) begin
                pins_r[sel_r] <= pins_r[sel_r] + 1'b1;
              end
              use_r <= use_r + 1'b1;
              if (policy_r == POL_CLOCK) begin
                stamp_r[sel_r] <= STAMP_W'(1);
              end else if (policy_r == POL_LRU) begin
                stamp_r[sel_r] <= use_r + 1'b1;
              end
              out_r.hit <= 1'b1;
            end
            FN_UNPIN: begin
              if (pins_r[sel_r] != '0) begin
                pins_r[sel_r] <= pins_r[sel_r] - 1'b1;
              end
            end
            FN_DIRTY: begin
              dirty_r[sel_r] <= 1'b1;
            end
            FN_FORCE: begin
              dirty_r[sel_r]    <= 1'b0;
              write_r           <= write_r + 1'b1;
              out_r.write_valid <= 1'b1;
              out_r.write_page  <= pdata_r;
              out_r.write_count <= write_r + 1'b1;
            end
            default: ;
          endcase
        end
        OP_NF_EMIT, OP_NOFREE: begin
          out_r             <= '0;
          out_r.status      <= (cmd.op == OP_NF_EMIT) ? ST_NOT_FOUND : ST_NO_FRAME;
          out_r.last        <= 1'b1;
          out_r.read_count  <= load_r;
          out_r.write_count <= write_r;
          out_valid_r       <= 1'b1;
        end
        OP_MOD_INIT: begin
          div_r  <= (policy_r == POL_CLOCK) ? COUNT_W'(hand_r) : load_r;
          rem_r  <= '0;
          mcnt_r <= '0;
        end
        OP_MOD_STEP: begin
          rem_r  <= mod_r[NUM_W-1:0];
          div_r  <= {div_r[COUNT_W-2:0], 1'b0};
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == MOD_CNT_W'(COUNT_W - 1)) begin
            ptr_r   <= IDX_W'(mod_r);
            steps_r <= '0;
          end
        end
        OP_FIFO_STEP: begin
          if (pins_ptr == '0) begin
            vict_r <= ptr_r;
          end else begin
            ptr_r   <= ptr_wrap;
            steps_r <= steps_r + 1'b1;
          end
        end
        OP_CLK_STEP: begin
          ptr_r   <= ptr_wrap;
          hand_r  <= ptr_wrap;
          steps_r <= steps_r + 1'b1;
          if (pins_ptr == '0) begin
            if (stamp_ptr != '0) begin
              stamp_r[ptr_r] <= '0;
            end else begin
              vict_r <= ptr_r;
            end
          end
        end
        OP_V_CAP: begin
          pdata_r <= ram_rdata;
        end
        OP_COMMIT: begin
          valid_r[vsel] <= 1'b1;
          dirty_r[vsel] <= 1'b0;
          pins_r[vsel]  <= PIN_W'(1);
          stamp_r[vsel] <= (policy_r == POL_CLOCK) ? STAMP_W'(1) : use_r + 1'b1;
          load_r        <= load_r + 1'b1;
          use_r         <= use_r + 1'b1;
          if (victim_dirty) begin
            write_r <= write_r + 1'b1;
          end
          out_r             <= '0;
          out_r.frame       <= FRAME_W'(vsel);
          out_r.read_valid  <= 1'b1;
          out_r.read_page   <= req_page_r;
          out_r.write_valid <= victim_dirty;
          out_r.write_page  <= victim_dirty ? pdata_r : '0;
          out_r.last        <= 1'b1;
          out_r.read_count  <= load_r + 1'b1;
          out_r.write_count <= victim_dirty ? write_r + 1'b1 : write_r;
          out_valid_r       <= 1'b1;
        end
        OP_FL_STEP: begin
          if (cmd.flush_none) begin
            out_r             <= '0;
            out_r.last        <= 1'b1;
            out_r.read_count  <= load_r;
            out_r.write_count <= write_r;
            out_valid_r       <= 1'b1;
          end else begin
            if (cond_v[idx_r]) begin
              dirty_r[idx_r]    <= 1'b0;
              write_r           <= write_r + 1'b1;
              out_r             <= '0;
              out_r.frame       <= FRAME_W'(idx_r);
              out_r.write_valid <= 1'b1;
              out_r.write_page  <= ram_rdata;
              out_r.last        <= !(|(cond_v & above_v));
              out_r.read_count  <= load_r;
              out_r.write_count <= write_r + 1'b1;
              out_valid_r       <= 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/pfrm_ctrl.sv
module pfrm_ctrl import pfrm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LK_RD    = 4'd1;
  localparam logic [3:0] S_LK_CMP   = 4'd2;
  localparam logic [3:0] S_HIT      = 4'd3;
  localparam logic [3:0] S_NF       = 4'd4;
  localparam logic [3:0] S_MOD_INIT = 4'd5;
  localparam logic [3:0] S_MOD      = 4'd6;
  localparam logic [3:0] S_FIFO     = 4'd7;
  localparam logic [3:0] S_CLK      = 4'd8;
  localparam logic [3:0] S_V_RD     = 4'd9;
  localparam logic [3:0] S_V_CAP    = 4'd10;
  localparam logic [3:0] S_COMMIT   = 4'd11;
  localparam logic [3:0] S_NOFREE   = 4'd12;
  localparam logic [3:0] S_FL_RD    = 4'd13;
  localparam logic [3:0] S_FL_CMP   = 4'd14;
  localparam logic [3:0] S_FL_NONE  = 4'd15;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_NONE;
    cmd.flush_none = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          case (in_func)
            FN_PIN, FN_UNPIN, FN_DIRTY, FN_FORCE: state_nxt = S_LK_RD;
            FN_FLUSH: state_nxt = S_FL_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LK_RD: begin
        cmd.op    = OP_LK_READ;
        state_nxt = S_LK_CMP;
      end
      S_LK_CMP: begin
        cmd.op = OP_LK_CMP;
        if (stat.lk_hit) begin
          state_nxt = S_HIT;
        end else if (!stat.idx_last) begin
          state_nxt = S_LK_RD;
        end else if (stat.func != FN_PIN) begin
          state_nxt = S_NF;
        end else if (stat.empty_any) begin
          state_nxt = S_COMMIT;
        end else if (stat.policy == POL_LRU) begin
          state_nxt = stat.lru_any ? S_V_RD : S_NOFREE;
        end else begin
          state_nxt = S_MOD_INIT;
        end
      end
      S_HIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_HIT_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_NF: begin
        if (stat.out_free) begin
          cmd.op    = OP_NF_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_MOD_INIT: begin
        cmd.op    = OP_MOD_INIT;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (stat.mod_done) begin
          state_nxt = (stat.policy == POL_CLOCK) ? S_CLK : S_FIFO;
        end
      end
      S_FIFO: begin
        cmd.op = OP_FIFO_STEP;
        if (stat.fifo_hit) begin
          state_nxt = S_V_RD;
        end else if (stat.fifo_end) begin
          state_nxt = S_NOFREE;
        end
      end
      S_CLK: begin
        cmd.op = OP_CLK_STEP;
        if (stat.clk_hit) begin
          state_nxt = S_V_RD;
        end else if (stat.clk_end) begin
          state_nxt = S_NOFREE;
        end
      end
      S_V_RD: begin
        cmd.op    = OP_V_READ;
        state_nxt = S_V_CAP;
      end
      S_V_CAP: begin
        cmd.op    = OP_V_CAP;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_COMMIT;
          state_nxt = S_IDLE;
        end
      end
      S_NOFREE: begin
        if (stat.out_free) begin
          cmd.op    = OP_NOFREE;
          state_nxt = S_IDLE;
        end
      end
      S_FL_RD: begin
        cmd.op    = OP_FL_READ;
        state_nxt = S_FL_CMP;
      end
      S_FL_CMP: begin
        // hold a write-back until the output slot frees
        if (!stat.fl_cond || stat.out_free) begin
          cmd.op = OP_FL_STEP;
          if (stat.fl_cond && !stat.fl_rest) begin
            state_nxt = S_IDLE;
          end else if (stat.idx_last) begin
            state_nxt = S_FL_NONE;
          end else begin
            state_nxt = S_FL_RD;
          end
        end
      end
      S_FL_NONE: begin
        if (stat.out_free) begin
          cmd.op         = OP_FL_STEP;
          cmd.flush_none = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/page_frame_replacement_manager_top.sv
// Channel    Dir  Handshake      Payload
// in_chan    in   valid/ready    func, page_num
// out_chan   out  valid/ready    status, hit, frame, read/write page, last, counts
// cfg        in   cfg_we only    cfg_index, cfg_data (0 policy, 1 frames_in_use)
//
// One request at a time. Lookup reads one frame at a time through the single page
// RAM port (registered read) for a pin hit or an unpin/dirty/force. A pin miss with
// no empty frame adds a restoring remainder step for FIFO/CLOCK, then a scan of up to
// n (FIFO) or 2n (CLOCK) frame positions and a read of the victim page. Flush also
// reads the frames one at a time and waits on output stalls.
// Reset is synchronous and needs no sweep.
// A finished result waits in the output register while the next request is taken.
module page_frame_replacement_manager_top import pfrm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pfrm_req_if.sink              in_chan,
  pfrm_rsp_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  rsp_t     out_data;
  logic     out_valid;

  pfrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfrm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (in_chan.func),
    .in_page   (in_chan.page_num),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_chan.valid       = out_valid;
  assign out_chan.status      = out_data.status;
  assign out_chan.hit         = out_data.hit;
  assign out_chan.frame       = out_data.frame;
  assign out_chan.read_valid  = out_data.read_valid;
  assign out_chan.read_page   = out_data.read_page;
  assign out_chan.write_valid = out_data.write_valid;
  assign out_chan.write_page  = out_data.write_page;
  assign out_chan.last        = out_data.last;
  assign out_chan.read_count  = out_data.read_count;
  assign out_chan.write_count = out_data.write_count;

endmodule

>>> hw/rtl/pfrm_checker.sv
module pfrm_checker import pfrm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STAT_W-1:0]   status,
  input logic                hit,
  input logic [FRAME_W-1:0]  frame,
  input logic                read_valid,
  input logic                write_valid,
  input logic                last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_valid |-> (status == ST_OK) && !hit && last)
    else $error("page read on a non-fill result");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (frame == '0) && last && !read_valid && !write_valid)
    else $error("error result carries payload");

  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit |-> !write_valid && !read_valid && last)
    else $error("hit reports disk traffic");

endmodule

bind page_frame_replacement_manager_top pfrm_checker u_pfrm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .status      (out_chan.status),
  .hit         (out_chan.hit),
  .frame       (out_chan.frame),
  .read_valid  (out_chan.read_valid),
  .write_valid (out_chan.write_valid),
  .last        (out_chan.last)
);

>>> verif/page_frame_replacement_manager_top_tb.sv
module page_frame_replacement_manager_top_tb;
  import pfrm_pkg::*;

  localparam int IDLE_LIMIT  = 6000;
  localparam int SETTLE_CYC  = 160;
  localparam int MAX_GAP     = 18;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit   quiet;

  pfrm_req_if req_if ();
  pfrm_rsp_if rsp_if ();

  page_frame_replacement_manager_top dut (
    .clk(clk), .rst_n(rst_n), .in_chan(req_if.sink), .out_chan(rsp_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  class frame_table_sb;
    logic [POL_W-1:0]     policy;
    logic [FR_W-1:0]      frames_cfg;
    logic [PAGE_BITS-1:0] page_of [POOL_FRAMES];
    bit                   resident [POOL_FRAMES];
    bit                   dirty [POOL_FRAMES];
    logic [PIN_W-1:0]     pins [POOL_FRAMES];
    logic [STAMP_W-1:0]   stamp [POOL_FRAMES];
    logic [COUNT_W-1:0]   loads, writes, uses;
    int                   hand;
    rsp_t                 pending [$];
    int                   errors;

    function void clear();
      policy = POL_FIFO;
      frames_cfg = FRAMES_RESET;
      for (int i = 0; i < POOL_FRAMES; i++) begin
        page_of[i] = '0; resident[i] = 0; dirty[i] = 0; pins[i] = '0; stamp[i] = '0;
      end
      loads = '0; writes = '0; uses = '0; hand = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_POLICY) policy = val[POL_W-1:0];
      else frames_cfg = val[FR_W-1:0];
    endfunction

    function int active();
      if (frames_cfg < 1) return 1;
      if (frames_cfg > POOL_FRAMES) return POOL_FRAMES;
      return frames_cfg;
    endfunction

    function void push(logic [STAT_W-1:0] st, bit h, int fr, bit rv,
                       logic [PAGE_BITS-1:0] rp, bit wv, logic [PAGE_BITS-1:0] wp, bit lst);
      rsp_t r;
      r.status = st; r.hit = h; r.frame = fr[FRAME_W-1:0];
      r.read_valid = rv; r.read_page = rp; r.write_valid = wv; r.write_page = wp;
      r.last = lst; r.read_count = loads; r.write_count = writes;
      pending.push_back(r);
    endfunction

    function int lookup(logic [PAGE_BITS-1:0] pg, int n);
      for (int i = 0; i < n; i++)
        if (resident[i] && page_of[i] == pg) return i;
      return -1;
    endfunction

    function void pin_page(logic [PAGE_BITS-1:0] pg, int n);
      int f, v, h, cur, start, j;
      bit wv;
      logic [PAGE_BITS-1:0] wp;
      f = lookup(pg, n);
      v = -1; wv = 0; wp = '0;
      if (f >= 0) begin
        if (pins[f] != 8'hFF) pins[f]++;
        uses++;
        if (policy == POL_CLOCK) stamp[f] = 1;
        else if (policy == POL_LRU) stamp[f] = uses;
        push(ST_OK, 1, f, 0, '0, 0, '0, 1);
        return;
      end
      for (int i = 0; i < n; i++)
        if (!resident[i]) begin v = i; break; end
      if (v < 0) begin
        if (policy == POL_LRU) begin
          for (int i = 0; i < n; i++)
            if (pins[i] == 0 && (v < 0 || stamp[i] < stamp[v])) v = i;
        end else if (policy == POL_CLOCK) begin
          h = hand % n;
          for (int s = 0; s < 2 * n; s++) begin
            cur = h;
            h = (h + 1) % n;
            if (pins[cur] != 0) continue;
            if (stamp[cur] != 0) begin stamp[cur] = 0; continue; end
            v = cur;
            break;
          end
          hand = h;
        end else begin
          start = loads % n;
          for (int i = 0; i < n; i++) begin
            j = (start + i) % n;
            if (pins[j] == 0) begin v = j; break; end
          end
        end
        if (v < 0) begin
          push(ST_NO_FRAME, 0, 0, 0, '0, 0, '0, 1);
          return;
        end
        if (dirty[v]) begin wv = 1; wp = page_of[v]; writes++; end
      end
      page_of[v] = pg; resident[v] = 1; dirty[v] = 0; pins[v] = 1;
      loads++; uses++;
      stamp[v] = (policy == POL_CLOCK) ? 32'd1 : uses;
      push(ST_OK, 0, v, 1, pg, wv, wp, 1);
    endfunction

    // Work out the results of one accepted request.
    function void note_request(logic [FUNC_W-1:0] fn, logic [PAGE_BITS-1:0] pg);
      int n, f, cnt;
      n = active();
      case (fn)
        FN_PIN: pin_page(pg, n);
        FN_UNPIN, FN_DIRTY, FN_FORCE: begin
          f = lookup(pg, n);
          if (f < 0) push(ST_NOT_FOUND, 0, 0, 0, '0, 0, '0, 1);
          else if (fn == FN_UNPIN) begin
            if (pins[f] != 0) pins[f]--;
            push(ST_OK, 0, f, 0, '0, 0, '0, 1);
          end else if (fn == FN_DIRTY) begin
            dirty[f] = 1;
            push(ST_OK, 0, f, 0, '0, 0, '0, 1);
          end else begin
            dirty[f] = 0;
            writes++;
            push(ST_OK, 0, f, 0, '0, 1, page_of[f], 1);
          end
        end
        FN_FLUSH: begin
          cnt = 0;
          for (int i = 0; i < n; i++)
            if (resident[i] && pins[i] == 0 && dirty[i]) begin
              dirty[i] = 0;
              writes++;
              push(ST_OK, 0, i, 0, '0, 1, page_of[i], 0);
              cnt++;
            end
          if (cnt == 0) push(ST_OK, 0, 0, 0, '0, 0, '0, 1);
          else pending[pending.size() - 1].last = 1;
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.hit !== exp.hit) report($sformatf("hit %0d, want %0d", got.hit, exp.hit));
      if (got.frame !== exp.frame)
        report($sformatf("frame %0d, want %0d", got.frame, exp.frame));
      if (got.read_valid !== exp.read_valid)
        report($sformatf("read_valid %0d, want %0d", got.read_valid, exp.read_valid));
      if (got.read_page !== exp.read_page)
        report($sformatf("read_page %h, want %h", got.read_page, exp.read_page));
      if (got.write_valid !== exp.write_valid)
        report($sformatf("write_valid %0d, want %0d", got.write_valid, exp.write_valid));
      if (got.write_page !== exp.write_page)
        report($sformatf("write_page %h, want %h", got.write_page, exp.write_page));
      if (got.last !== exp.last) report($sformatf("last %0d, want %0d", got.last, exp.last));
      if (got.read_count !== exp.read_count)
        report($sformatf("read_count %0d, want %0d", got.read_count, exp.read_count));
      if (got.write_count !== exp.write_count)
        report($sformatf("write_count %0d, want %0d", got.write_count, exp.write_count));
    endtask
  endclass

  frame_table_sb sb;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles without any handshake.
  int stuck;
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= IDLE_LIMIT) begin
      $display("page_frame_replacement_manager_top_tb: done, errors");
      $finish;
    end
  end

  // Result side: random stall before each result.
  initial begin
    rsp_t got;
    int stall;
    rsp_if.ready = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        rsp_if.ready <= 0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1;
      do @(posedge clk); while (!rsp_if.valid);
      got.status = rsp_if.status; got.hit = rsp_if.hit; got.frame = rsp_if.frame;
      got.read_valid = rsp_if.read_valid; got.read_page = rsp_if.read_page;
      got.write_valid = rsp_if.write_valid; got.write_page = rsp_if.write_page;
      got.last = rsp_if.last; got.read_count = rsp_if.read_count;
      got.write_count = rsp_if.write_count;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  task send(logic [FUNC_W-1:0] fn, logic [PAGE_BITS-1:0] pg);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1;
    req_if.func <= fn;
    req_if.page_num <= pg;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(fn, pg);
    @(negedge clk);
  endtask

  // Hold until every outstanding result is back, then let the block settle.
  task drain();
    req_if.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task set_mode(logic [POL_W-1:0] pol, logic [FR_W-1:0] fr);
    drain();
    write_reg(REG_POLICY, CFG_DATA_W'(pol));
    write_reg(REG_FRAMES, CFG_DATA_W'(fr));
  endtask

  task random_burst(int count, int span);
    logic [PAGE_BITS-1:0] base, pg;
    int r;
    logic [FUNC_W-1:0] fn;
    base = PAGE_BITS'($urandom);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) fn = FN_PIN;
      else if (r < 64) fn = FN_UNPIN;
      else if (r < 76) fn = FN_DIRTY;
      else if (r < 85) fn = FN_FORCE;
      else if (r < 94) fn = FN_FLUSH;
      else fn = FUNC_W'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0) pg = PAGE_BITS'($urandom);
      else pg = base + PAGE_BITS'($urandom_range(0, span));
      send(fn, pg);
    end
  endtask

  logic [POL_W-1:0] pol_list [10] = '{POL_FIFO, POL_LRU, POL_CLOCK, POL_LRU, POL_CLOCK,
                                      2'd3, POL_FIFO, POL_CLOCK, POL_LRU, POL_FIFO};
  logic [FR_W-1:0]  fr_list  [10] = '{5'd4, 5'd4, 5'd4, 5'd16, 5'd1,
                                      5'd3, 5'd0, 5'd31, 5'd17, 5'd2};

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    req_if.valid = 0; req_if.func = FN_PIN; req_if.page_num = '0;
    quiet = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    write_reg(REG_POLICY, CFG_DATA_W'(POL_FIFO));
    write_reg(REG_FRAMES, CFG_DATA_W'(16));
    send(FN_PIN, '0);
    send(FN_PIN, '1);
    send(FN_PIN, '0);
    send(FN_UNPIN, '1);
    send(FN_UNPIN, '1);
    send(FN_UNPIN, 20'h12345);
    send(FN_DIRTY, '0);
    send(FN_FORCE, '0);
    send(FN_FORCE, '1);
    send(FN_DIRTY, '1);
    send(FN_FLUSH, 20'hABCDE);
    send(FN_FLUSH, '0);
    send(3'd5, '1);
    send(3'd6, '0);
    send(3'd7, 20'h55555);
    send(FN_DIRTY, 20'h00777);
    // pool of one frame, already pinned: no frame to replace
    set_mode(POL_FIFO, 5'd1);
    send(FN_PIN, '0);
    send(FN_PIN, 20'h00042);
    set_mode(POL_CLOCK, 5'd1);
    send(FN_PIN, 20'h00042);
    send(FN_UNPIN, '0);
    send(FN_UNPIN, '0);
    send(FN_PIN, 20'h00042);

    // pin count held at zero when unpinned too often
    set_mode(POL_LRU, 5'd4);
    quiet = 1;
    for (int k = 0; k < 3; k++) send(FN_PIN, 20'h00007);
    for (int k = 0; k < 5; k++) send(FN_UNPIN, 20'h00007);
    quiet = 0;

    for (int p = 0; p < 10; p++) begin
      set_mode(pol_list[p], fr_list[p]);
      quiet = ($urandom_range(0, 3) == 0);
      random_burst(20, (fr_list[p] > 8) ? 24 : 7);
    end
    quiet = 0;

    drain();
    if (sb.pending.size() != 0) sb.report("results never arrived");
    if (sb.errors == 0) begin
      $display("page_frame_replacement_manager_top_tb: done, clean");
    end else begin
      $display("page_frame_replacement_manager_top_tb: done, errors");
    end
    $finish;
  end

endmodule
